[rtl/multi_console_line_editor_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-console line editor
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_CONSOLE_LINE_EDITOR_MACROS_SVH
`define MULTI_CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MCLE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line editor check failed");

// Next-cycle implication, disabled during reset
`define MCLE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line editor check failed");

`endif

[rtl/mcle_pkg.sv]
// ----------------------------------------------------------------------------
// mcle_pkg
// Types, constants and helpers shared by the line editor modules.
// ----------------------------------------------------------------------------
package mcle_pkg;

   localparam int NUM_CONSOLES = 4;
   localparam int LINE_DEPTH   = 128;
   localparam int QUEUE_DEPTH  = 2;

   localparam int CON_W  = $clog2(NUM_CONSOLES);
   localparam int SLOT_W = $clog2(LINE_DEPTH);
   localparam int ADDR_W = $clog2(NUM_CONSOLES * LINE_DEPTH);
   localparam int CNT_W  = $clog2(LINE_DEPTH + 1);

   // action codes
   localparam logic [1:0] ACT_KEY   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // special characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_CTRL_B = 8'h02;
   localparam logic [7:0] CH_CTRL_D = 8'h04;
   localparam logic [7:0] CH_CTRL_H = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_CTRL_N = 8'h0E;
   localparam logic [7:0] CH_CTRL_P = 8'h10;
   localparam logic [7:0] CH_CTRL_U = 8'h15;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   typedef enum logic [2:0] {
      KIND_ECHO   = 3'd0,
      KIND_ERASE  = 3'd1,
      KIND_READ   = 3'd2,
      KIND_EMPTY  = 3'd3,
      KIND_EOF    = 3'd4,
      KIND_SWITCH = 3'd5,
      KIND_DUMP   = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      OP_NEXT,
      OP_PREV,
      OP_DUMP,
      OP_KILL,
      OP_ERASE,
      OP_CHAR,
      OP_READ,
      OP_WRITE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [CON_W-1:0]   console;
      logic [7:0]         data;
      logic               first;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } q_in_type;

   typedef struct packed {
      logic      avail;
      entry_type entry;
   } q_out_type;

   typedef struct packed {
      logic               wrap;
      logic [SLOT_W-1:0]  slot;
   } pos_type;

   typedef struct packed {
      kind_type           kind;
      logic [CON_W-1:0]   console;
      logic [7:0]         byte_out;
      logic [7:0]         erase_count;
      logic               line_end;
   } rsp_type;

   function automatic pos_type pos_inc(pos_type p);
      pos_type r;
      r = p;
      if (p.slot == SLOT_W'(LINE_DEPTH - 1)) begin
         r.slot = '0;
         r.wrap = ~p.wrap;
      end else begin
         r.slot = p.slot + SLOT_W'(1);
      end
      return r;
   endfunction

   function automatic pos_type pos_dec(pos_type p);
      pos_type r;
      r = p;
      if (p.slot == '0) begin
         r.slot = SLOT_W'(LINE_DEPTH - 1);
         r.wrap = ~p.wrap;
      end else begin
         r.slot = p.slot - SLOT_W'(1);
      end
      return r;
   endfunction

   // ring holds LINE_DEPTH bytes between read and edit positions
   function automatic logic ring_full(pos_type ed, pos_type rd);
      return (ed.wrap != rd.wrap) && (ed.slot == rd.slot);
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(logic [CON_W-1:0] con,
                                                    logic [SLOT_W-1:0] slot);
      logic [31:0] base;
      base = 32'(con) * 32'(LINE_DEPTH);
      return ADDR_W'(base) + ADDR_W'(slot);
   endfunction

   function automatic logic [7:0] sat_count(logic [CNT_W-1:0] cnt);
      logic [31:0] w;
      w = 32'(cnt);
      return (w > 32'd255) ? 8'hFF : w[7:0];
   endfunction

endpackage

[rtl/mcle_front.sv]
// ----------------------------------------------------------------------------
// mcle_front
// Accepts request transfers, decodes them into operations and pushes them.
// ----------------------------------------------------------------------------
module mcle_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic [1:0]           req_console,
   input  logic [7:0]           req_data,
   input  logic                 req_first_of_read,
   input  logic                 q_full,
   output mcle_pkg::q_in_type   q_in
);
   import mcle_pkg::*;

   logic keep;
   logic con_ok;

   assign con_ok    = 32'(req_console) < 32'(NUM_CONSOLES);
   assign req_stall = q_full;

   always_comb begin
      keep             = 1'b1;
      q_in.entry.op    = OP_CHAR;
      q_in.entry.console = CON_W'(req_console);
      q_in.entry.data  = req_data;
      q_in.entry.first = req_first_of_read;
      unique case (req_action)
         ACT_KEY: begin
            unique case (req_data)
               CH_CTRL_N: q_in.entry.op = OP_NEXT;
               CH_CTRL_B: q_in.entry.op = OP_PREV;
               CH_CTRL_P: q_in.entry.op = OP_DUMP;
               CH_CTRL_U: q_in.entry.op = OP_KILL;
               CH_CTRL_H, CH_DEL: q_in.entry.op = OP_ERASE;
               CH_NUL: keep = 1'b0;
               CH_CR: q_in.entry.data = CH_LF;
               default: q_in.entry.op = OP_CHAR;
            endcase
         end
         ACT_READ: begin
            q_in.entry.op = OP_READ;
            keep          = con_ok;
         end
         ACT_WRITE: begin
            q_in.entry.op = OP_WRITE;
            keep          = con_ok;
         end
         default: keep = 1'b0;
      endcase
      // drop ignored items at acceptance
      q_in.push = req_valid && !q_full && keep;
   end

endmodule

[rtl/mcle_queue.sv]
// ----------------------------------------------------------------------------
// mcle_queue
// Short FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module mcle_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mcle_pkg::q_in_type   q_in,
   input  logic                 pop,
   output logic                 q_full,
   output mcle_pkg::q_out_type  q_out
);
   import mcle_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;
   logic               do_pop;

   assign q_full      = count_ff == CNT_QW'(QUEUE_DEPTH);
   assign q_out.avail = count_ff != '0;
   assign q_out.entry = slots_ff[rd_ptr_ff];
   assign do_pop      = pop && q_out.avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_in.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (q_in.push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (!q_in.push && do_pop) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_in.push) begin
         slots_ff[wr_ptr_ff] <= q_in.entry;
      end
   end

endmodule

[rtl/mcle_back.sv]
// ----------------------------------------------------------------------------
// mcle_back
// Executes operations on the console rings and registers the response.
// ----------------------------------------------------------------------------
module mcle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mcle_pkg::q_out_type  q_out,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mcle_pkg::rsp_type    rsp
);
   import mcle_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_DATA,
      ST_KILL_LOOK,
      ST_KILL_CHECK
   } state_type;

   state_type         state_ff, state_in;
   entry_type         cur_ff, cur_in;
   logic [CON_W-1:0]  active_ff, active_in;
   pos_type           read_ff [NUM_CONSOLES];
   pos_type           read_in [NUM_CONSOLES];
   pos_type           commit_ff [NUM_CONSOLES];
   pos_type           commit_in [NUM_CONSOLES];
   pos_type           edit_ff [NUM_CONSOLES];
   pos_type           edit_in [NUM_CONSOLES];
   logic [CNT_W-1:0]  kill_cnt_ff, kill_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [7:0]        store [NUM_CONSOLES * LINE_DEPTH];
   logic [7:0]        mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;

   logic [CON_W-1:0]  a_con;
   logic [CON_W-1:0]  next_con;
   logic [CON_W-1:0]  prev_con;
   pos_type           rd_pos, cm_pos, ed_pos, ed_dec, ed_inc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // keyboard ops work on the active console, reads and writes on their own
   assign a_con    = (cur_ff.op inside {OP_READ, OP_WRITE}) ? cur_ff.console : active_ff;
   assign next_con = (active_ff == CON_W'(NUM_CONSOLES - 1)) ? '0 : active_ff + CON_W'(1);
   assign prev_con = (active_ff == '0) ? CON_W'(NUM_CONSOLES - 1) : active_ff - CON_W'(1);
   assign rd_pos   = read_ff[a_con];
   assign cm_pos   = commit_ff[a_con];
   assign ed_pos   = edit_ff[a_con];
   assign ed_dec   = pos_dec(ed_pos);
   assign ed_inc   = pos_inc(ed_pos);

   assign pop = (state_ff == ST_IDLE) && q_out.avail && (!rsp_valid_ff || !rsp_stall);

   assign mem_waddr = store_addr(a_con, ed_pos.slot);
   assign mem_raddr = (state_ff == ST_KILL_LOOK) ? store_addr(a_con, ed_dec.slot)
                                                 : store_addr(a_con, rd_pos.slot);
   assign mem_we    = (state_ff == ST_EXEC) && (cur_ff.op == OP_CHAR) &&
                      !ring_full(ed_pos, rd_pos);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      active_in    = active_ff;
      read_in      = read_ff;
      commit_in    = commit_ff;
      edit_in      = edit_ff;
      kill_cnt_in  = kill_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_in   = q_out.entry;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cur_ff.op)
               OP_NEXT: begin
                  active_in    = next_con;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{KIND_SWITCH, next_con, 8'h00, 8'h00, 1'b0};
               end
               OP_PREV: begin
                  active_in    = prev_con;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{KIND_SWITCH, prev_con, 8'h00, 8'h00, 1'b0};
               end
               OP_DUMP: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{KIND_DUMP, a_con, 8'h00, 8'h00, 1'b0};
               end
               OP_KILL: begin
                  kill_cnt_in = '0;
                  state_in    = ST_KILL_LOOK;
               end
               OP_ERASE: begin
                  if (ed_pos != cm_pos) begin
                     edit_in[a_con] = ed_dec;
                     rsp_valid_in   = 1'b1;
                     rsp_in         = '{KIND_ERASE, a_con, 8'h00, 8'h01, 1'b0};
                  end
               end
               OP_CHAR: begin
                  if (!ring_full(ed_pos, rd_pos)) begin
                     edit_in[a_con] = ed_inc;
                     if (cur_ff.data == CH_LF || cur_ff.data == CH_CTRL_D ||
                         ring_full(ed_inc, rd_pos)) begin
                        commit_in[a_con] = ed_inc;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_ECHO, a_con, cur_ff.data, 8'h00, 1'b0};
                  end
               end
               OP_READ: begin
                  if (rd_pos == cm_pos) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_EMPTY, a_con, 8'h00, 8'h00, 1'b0};
                  end else begin
                     state_in = ST_READ_DATA;
                  end
               end
               OP_WRITE: begin
                  if (cur_ff.console == active_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_ECHO, a_con, cur_ff.data, 8'h00, 1'b0};
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_READ_DATA: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (mem_q_ff == CH_CTRL_D) begin
               // end-of-file marker stays unless it opens the read call
               if (cur_ff.first) begin
                  read_in[a_con] = pos_inc(rd_pos);
               end
               rsp_in = '{KIND_EOF, a_con, 8'h00, 8'h00, 1'b0};
            end else begin
               read_in[a_con] = pos_inc(rd_pos);
               rsp_in = '{KIND_READ, a_con, mem_q_ff, 8'h00, mem_q_ff == CH_LF};
            end
         end
         ST_KILL_LOOK: begin
            if (ed_pos == cm_pos) begin
               state_in = ST_IDLE;
               if (kill_cnt_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{KIND_ERASE, a_con, 8'h00, sat_count(kill_cnt_ff), 1'b0};
               end
            end else begin
               state_in = ST_KILL_CHECK;
            end
         end
         ST_KILL_CHECK: begin
            if (mem_q_ff == CH_LF) begin
               state_in = ST_IDLE;
               if (kill_cnt_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{KIND_ERASE, a_con, 8'h00, sat_count(kill_cnt_ff), 1'b0};
               end
            end else begin
               edit_in[a_con] = ed_dec;
               kill_cnt_in    = kill_cnt_ff + CNT_W'(1);
               state_in       = ST_KILL_LOOK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= CON_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CONSOLES; i++) begin
            read_ff[i]   <= '0;
            commit_ff[i] <= '0;
            edit_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
      end
      cur_ff      <= cur_in;
      kill_cnt_ff <= kill_cnt_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= cur_ff.data;
      end
      mem_q_ff <= store[mem_raddr];
   end

endmodule

[rtl/multi_console_line_editor.sv]
// ----------------------------------------------------------------------------
// multi_console_line_editor
// Canonical line editing for several virtual consoles sharing one keyboard.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries keyboard bytes (action 0), one-byte reads (action 1) and
//   one-byte writes (action 2); rsp_* returns at most one result per item:
//   echo, erase, read byte / empty / eof, console switch or dump request.
//   Items with no result (dropped bytes, nothing to erase, writes to an
//   inactive console, bad console numbers) are simply absorbed.
// Execution:
//   An item waits in a two-entry queue, then passes through the back end
//   in a dequeue step and an execute step; reads add a step on the ring
//   memory's registered port. A kill-line item walks the ring back one
//   character at a time, with a look step and a check step per character.
// Reset:
//   All ring positions go to zero and console 1 becomes active; the ring
//   memory itself is not cleared (it is only read after being written).
// Stall:
//   A stalled result holds in the output register; the back end starts no
//   new item until it is free, while the queue still takes up to two
//   transfers before req_stall rises.
// ----------------------------------------------------------------------------
module multi_console_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_console,
   input  logic [7:0]  req_data,
   input  logic        req_first_of_read,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_console_id,
   output logic [7:0]  rsp_byte_out,
   output logic [7:0]  rsp_erase_count,
   output logic        rsp_line_end
);
   import mcle_pkg::*;

   q_in_type  q_in;
   q_out_type q_out;
   logic      q_full;
   logic      pop;
   rsp_type   rsp;

   // Front: decode each transfer, drop ignored ones, stall only on a full queue
   mcle_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_console       (req_console),
      .req_data          (req_data),
      .req_first_of_read (req_first_of_read),
      .q_full            (q_full),
      .q_in              (q_in)
   );

   // Queue: decouple decoding from execution
   mcle_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_in   (q_in),
      .pop    (pop),
      .q_full (q_full),
      .q_out  (q_out)
   );

   // Back: ring state, line memory and the registered response
   mcle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Drive result fields straight from the output register
   assign rsp_kind        = rsp.kind;
   assign rsp_console_id  = 2'(rsp.console);
   assign rsp_byte_out    = rsp.byte_out;
   assign rsp_erase_count = rsp.erase_count;
   assign rsp_line_end    = rsp.line_end;

endmodule

[rtl/mcle_checker.sv]
// ----------------------------------------------------------------------------
// mcle_checker
// Port-level checks on the line editor's result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "multi_console_line_editor_macros.svh"

module mcle_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [1:0]  rsp_console_id,
   input  logic [7:0]  rsp_byte_out,
   input  logic [7:0]  rsp_erase_count,
   input  logic        rsp_line_end
);
   import mcle_pkg::*;

   // a stalled result holds
   `MCLE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_console_id) &&
      $stable(rsp_byte_out) && $stable(rsp_erase_count) && $stable(rsp_line_end))

   // only echoes and read bytes carry a byte
   `MCLE_ASSERT_IMP(a_byte_kind, clock, reset, rsp_valid && rsp_byte_out != 8'h00,
      rsp_kind == KIND_ECHO || rsp_kind == KIND_READ)

   // an erase result always erases something, others never do
   `MCLE_ASSERT_IMP(a_erase_cnt, clock, reset, rsp_valid,
      (rsp_kind == KIND_ERASE) == (rsp_erase_count != 8'h00))

   // line end marks a newline read
   `MCLE_ASSERT_IMP(a_line_end, clock, reset, rsp_valid && rsp_line_end,
      rsp_kind == KIND_READ && rsp_byte_out == CH_LF)

endmodule

bind multi_console_line_editor mcle_checker u_checker (.*);
